FILE: sv/etsa_pkg.sv
// ----------------------------------------------------------------------------
// etsa_pkg: shared types and constants of the event time spectrum accumulator
// Request and operation codes, the stream item passed along the cell row,
// saturating sum arithmetic and the quarter-wave cosine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package etsa_pkg;

    localparam int DEF_MODE_COUNT  = 4;
    localparam int DEF_POINT_COUNT = 256;
    localparam int DEF_TABLE_BITS  = 10;

    localparam int SUM_W    = 48;
    localparam int SMP_W    = 18;
    localparam int QMAG_W   = 17;
    localparam int PT_MAX_W = 12;
    localparam int ADDR_W   = 3;
    localparam int PHASE_W  = 32;
    localparam int PIU_W    = 9;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic REG_PHASE_STEP    = 1'b0;
    localparam logic REG_POINTS_IN_USE = 1'b1;

    localparam logic [PIU_W-1:0] PIU_RESET = 9'd256;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_TOP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                       valid;
        op_t                        op;
        logic [1:0]                 mode;
        logic [PT_MAX_W-1:0]        point;
        logic                       hit;
        logic signed [SUM_W-1:0]    re;
        logic signed [SUM_W-1:0]    im;
    } item_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s,
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W:0] r;
        r = {s[SUM_W-1], s} + {v[SUM_W-1], v};
        if (r[SUM_W] != r[SUM_W-1])
        begin
            return r[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return r[SUM_W-1:0];
    endfunction

    // (a*b) >> 62 in Q62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // floor(a/d) by shift and subtract, evaluated at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(131071 * cos(pi/2 * j / 2^(tb-2))), evaluated at elaboration
    function automatic logic [QMAG_W-1:0] quarter_cos(input int unsigned j,
                                                      input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] div;
        if (j >= (32'd1 << (tb - 2)))
        begin
            return '0;
        end
        x    = (HALF_PI_Q62 >> (tb - 2)) * 64'(j);
        x2   = mul_q62(x, x);
        term = ONE_Q62;
        sum  = ONE_Q62;
        for (int unsigned n = 1; n <= 13; n++)
        begin
            div  = 64'((2 * n - 1) * (2 * n));
            term = udiv64(mul_q62(term, x2), div);
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        v = (sum >> 20) * 64'd131071;
        return QMAG_W'((v + (64'd1 << 41)) >> 42);
    endfunction

endpackage

`default_nettype wire

FILE: sv/etsa_sample_gen.sv
// ----------------------------------------------------------------------------
// etsa_sample_gen: cosine and sine samples of a 32-bit turn fraction
// Quarter-wave table lookup with symmetry folding, Q1.17 samples.
// ----------------------------------------------------------------------------
`default_nettype none

module etsa_sample_gen #(
    parameter int TABLE_BITS = etsa_pkg::DEF_TABLE_BITS
) (
    input  wire logic [etsa_pkg::PHASE_W-1:0]        phase,
    output logic signed [etsa_pkg::SMP_W-1:0]        cos_smp,
    output logic signed [etsa_pkg::SMP_W-1:0]        sin_smp
);

    localparam int TAB_Q  = 1 << (TABLE_BITS - 2);
    localparam int QMAG_W = etsa_pkg::QMAG_W;
    localparam int SMP_W  = etsa_pkg::SMP_W;

    logic [QMAG_W-1:0] qtab [TAB_Q];

    for (genvar g = 0; g < TAB_Q; g++)
    begin : g_tab
        localparam logic [QMAG_W-1:0] ENTRY = etsa_pkg::quarter_cos(g, TABLE_BITS);
        assign qtab[g] = ENTRY;
    end

    function automatic logic signed [SMP_W-1:0] fold(input logic [TABLE_BITS-1:0] idx);
        logic [1:0]            quad;
        logic [TABLE_BITS-3:0] j;
        logic [TABLE_BITS-3:0] rj;
        logic [QMAG_W-1:0]     mag;
        logic signed [SMP_W-1:0] pos;
        quad = idx[TABLE_BITS-1 -: 2];
        j    = idx[TABLE_BITS-3:0];
        rj   = '0 - j;
        if (quad[0])
            mag = (j == '0) ? '0 : qtab[rj];
        else
            mag = qtab[j];
        pos = $signed({1'b0, mag});
        return (quad == 2'd1 || quad == 2'd2) ? -pos : pos;
    endfunction

    logic [TABLE_BITS-1:0] cos_idx;
    logic [TABLE_BITS-1:0] sin_idx;

    assign cos_idx = phase[etsa_pkg::PHASE_W-1 -: TABLE_BITS];
    assign sin_idx = cos_idx - TABLE_BITS'(TAB_Q);
    assign cos_smp = fold(cos_idx);
    assign sin_smp = fold(sin_idx);

endmodule

`default_nettype wire

FILE: sv/etsa_cell.sv
// ----------------------------------------------------------------------------
// etsa_cell: one frequency point of the accumulator row
// Holds the real and imaginary sums of its point for every mode, acts on an
// add or read addressed to it and on any clear, hands items to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module etsa_cell #(
    parameter int MODE_COUNT = etsa_pkg::DEF_MODE_COUNT,
    parameter int CELL_INDEX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire etsa_pkg::item_t item_in,
    output etsa_pkg::item_t      item_out
);

    localparam int SUM_W  = etsa_pkg::SUM_W;
    localparam int PTW    = etsa_pkg::PT_MAX_W;
    localparam int MODE_W = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
    localparam logic [PTW-1:0] MY_POINT = PTW'(CELL_INDEX);

    logic signed [SUM_W-1:0] cos_sum_reg [MODE_COUNT];
    logic signed [SUM_W-1:0] sin_sum_reg [MODE_COUNT];
    logic signed [SUM_W-1:0] cos_sel;
    logic signed [SUM_W-1:0] sin_sel;
    logic [MODE_W-1:0]       m;
    logic                    here;
    logic                    do_add;
    logic                    do_clear;
    etsa_pkg::item_t         item_reg;
    etsa_pkg::item_t         item_next;

    assign m        = MODE_W'(item_in.mode);
    assign here     = item_in.valid && item_in.hit && (item_in.point == MY_POINT);
    assign do_add   = here && (item_in.op == etsa_pkg::OP_ADD);
    assign do_clear = item_in.valid && (item_in.op == etsa_pkg::OP_CLEAR);
    assign cos_sel  = cos_sum_reg[m];
    assign sin_sel  = sin_sum_reg[m];

    always_comb
    begin
        item_next = item_in;
        if (here && item_in.op == etsa_pkg::OP_READ)
        begin
            item_next.re = cos_sel;
            item_next.im = sin_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODE_COUNT; i++)
            begin
                cos_sum_reg[i] <= '0;
                sin_sum_reg[i] <= '0;
            end
        end
        else if (do_clear)
        begin
            for (int i = 0; i < MODE_COUNT; i++)
            begin
                cos_sum_reg[i] <= '0;
                sin_sum_reg[i] <= '0;
            end
        end
        else if (do_add)
        begin
            cos_sum_reg[m] <= etsa_pkg::sat_add(cos_sel, item_in.re);
            sin_sum_reg[m] <= etsa_pkg::sat_add(sin_sel, item_in.im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else
            item_reg <= item_next;
    end

    assign item_out = item_reg;

endmodule

`default_nettype wire

FILE: sv/event_time_spectrum_accumulator.sv
// ----------------------------------------------------------------------------
// event_time_spectrum_accumulator: per-mode spectral sums of event times
// Fixed-point nonuniform DFT accumulated over a row of frequency-point cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests are accepted when start is high and busy is low. An add request
//   (mode, event_time) adds cos/sin of (k+1)*base phase to bin k of the mode
//   for k below points_in_use. A read request (mode, bin_index) returns one
//   transfer on real_sum/imag_sum marked by done. A clear zeroes all sums.
//   A read or clear travels as one item down the cell row, an add as one
//   item per point in use, one cell per cycle; later items never overtake
//   earlier ones, so requests act in order.
// Throughput and sequencing:
//   Add: busy after acceptance through BASE and TOP, whose multiplies form
//   the base and top phase, then EMIT, one item per point into the row.
//   Read and clear: one per cycle while no add holds busy; neither raises busy.
// Reset:
//   All sums cleared at once, phase_step 0, points_in_use 256.
//   The receiver cannot stall: each done pulse is one transfer.
// Config: APB, phase_step at 0x0, points_in_use at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module event_time_spectrum_accumulator #(
    parameter int MODE_COUNT  = etsa_pkg::DEF_MODE_COUNT,
    parameter int POINT_COUNT = etsa_pkg::DEF_POINT_COUNT,
    parameter int TABLE_BITS  = etsa_pkg::DEF_TABLE_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [etsa_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     req_type,
    input  wire logic [1:0]                     mode_index,
    input  wire logic [47:0]                    event_time,
    input  wire logic [7:0]                     bin_index,
    output logic                                done,
    output logic signed [etsa_pkg::SUM_W-1:0]   real_sum,
    output logic signed [etsa_pkg::SUM_W-1:0]   imag_sum
);

    localparam int SUM_W   = etsa_pkg::SUM_W;
    localparam int SMP_W   = etsa_pkg::SMP_W;
    localparam int PTW     = etsa_pkg::PT_MAX_W;
    localparam int PHASE_W = etsa_pkg::PHASE_W;
    localparam int PIU_W   = etsa_pkg::PIU_W;
    localparam int CNT_W   = $clog2(POINT_COUNT + 1);

    // ---------------- configuration ----------------
    logic [PHASE_W-1:0] phase_step_reg;
    logic [PIU_W-1:0]   points_in_use_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= '0;
            points_in_use_reg <= etsa_pkg::PIU_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                etsa_pkg::REG_PHASE_STEP:    phase_step_reg    <= pwdata;
                etsa_pkg::REG_POINTS_IN_USE: points_in_use_reg <= pwdata[PIU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            etsa_pkg::REG_PHASE_STEP:    prdata = phase_step_reg;
            etsa_pkg::REG_POINTS_IN_USE: prdata = {{(32-PIU_W){1'b0}}, points_in_use_reg};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- request sequencer ----------------
    etsa_pkg::state_t      state_reg, state_next;
    logic [PHASE_W-1:0]    t_reg, t_next;
    logic [1:0]            mode_reg, mode_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [PHASE_W-1:0]    base_reg, base_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    etsa_pkg::item_t       inj_reg, inj_next;
    logic [CNT_W-1:0]      n_cfg;
    logic                  mode_ok;
    logic                  bin_ok;
    logic signed [SMP_W-1:0] cos_smp;
    logic signed [SMP_W-1:0] sin_smp;

    assign n_cfg   = (32'(points_in_use_reg) > 32'(POINT_COUNT)) ? CNT_W'(POINT_COUNT)
                                                                 : CNT_W'(points_in_use_reg);
    assign mode_ok = 32'(mode_index) < 32'(MODE_COUNT);
    assign bin_ok  = 32'(bin_index) < 32'(POINT_COUNT);
    assign busy    = (state_reg != etsa_pkg::ST_IDLE);

    etsa_sample_gen #(
        .TABLE_BITS (TABLE_BITS)
    ) u_sample_gen (
        .phase   (phase_reg),
        .cos_smp (cos_smp),
        .sin_smp (sin_smp)
    );

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        mode_next  = mode_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        phase_next = phase_reg;
        inj_next   = '0;
        case (state_reg)
            etsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        etsa_pkg::REQ_ADD:
                        begin
                            if (mode_ok && n_cfg != '0)
                            begin
                                t_next     = event_time[PHASE_W-1:0];
                                mode_next  = mode_index;
                                n_next     = n_cfg;
                                state_next = etsa_pkg::ST_BASE;
                            end
                        end
                        etsa_pkg::REQ_READ:
                        begin
                            inj_next.valid = 1'b1;
                            inj_next.op    = etsa_pkg::OP_READ;
                            inj_next.mode  = mode_index;
                            inj_next.point = PTW'(bin_index);
                            inj_next.hit   = mode_ok && bin_ok;
                        end
                        etsa_pkg::REQ_CLEAR:
                        begin
                            inj_next.valid = 1'b1;
                            inj_next.op    = etsa_pkg::OP_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            etsa_pkg::ST_BASE:
            begin
                base_next  = PHASE_W'(t_reg * phase_step_reg);
                state_next = etsa_pkg::ST_TOP;
            end
            etsa_pkg::ST_TOP:
            begin
                phase_next = PHASE_W'(base_reg * n_reg);
                k_next     = n_reg - 1'b1;
                state_next = etsa_pkg::ST_EMIT;
            end
            etsa_pkg::ST_EMIT:
            begin
                // points go in highest first so all reach their cells together
                inj_next.valid = 1'b1;
                inj_next.op    = etsa_pkg::OP_ADD;
                inj_next.mode  = mode_reg;
                inj_next.point = PTW'(k_reg);
                inj_next.hit   = 1'b1;
                inj_next.re    = {{(SUM_W-SMP_W){cos_smp[SMP_W-1]}}, cos_smp};
                inj_next.im    = {{(SUM_W-SMP_W){sin_smp[SMP_W-1]}}, sin_smp};
                phase_next     = phase_reg - base_reg;
                k_next         = k_reg - 1'b1;
                if (k_reg == '0)
                    state_next = etsa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = etsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= etsa_pkg::ST_IDLE;
            inj_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= inj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        mode_reg  <= mode_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        base_reg  <= base_next;
        phase_reg <= phase_next;
    end

    // ---------------- cell row ----------------
    etsa_pkg::item_t chain [POINT_COUNT];

    for (genvar j = 0; j < POINT_COUNT; j++)
    begin : g_cell
        etsa_pkg::item_t cell_in;
        if (j == 0)
        begin : g_head
            assign cell_in = inj_reg;
        end
        else
        begin : g_body
            assign cell_in = chain[j-1];
        end
        etsa_cell #(
            .MODE_COUNT (MODE_COUNT),
            .CELL_INDEX (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .item_in  (cell_in),
            .item_out (chain[j])
        );
    end

    assign done     = chain[POINT_COUNT-1].valid &&
                      (chain[POINT_COUNT-1].op == etsa_pkg::OP_READ);
    assign real_sum = chain[POINT_COUNT-1].re;
    assign imag_sum = chain[POINT_COUNT-1].im;

    // ---------------- assertions ----------------
    a_busy_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(req_type) == etsa_pkg::REQ_ADD)
        else $error("busy rose without an accepted add");

    a_emit_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == etsa_pkg::ST_EMIT && k_reg != '0)
        |=> (state_reg == etsa_pkg::ST_EMIT) && (k_reg == $past(k_reg) - 1'b1))
        else $error("point countdown broken during emission");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == etsa_pkg::REQ_READ) |-> ##(POINT_COUNT+1) done)
        else $error("read result missing after the cell row");

endmodule

`default_nettype wire

FILE: sim/spectrum_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_checker: predicts and checks the spectrum accumulator's read data
// Tracks register writes and accepted requests and keeps its own copy of
// the per-mode cosine and sine sums, built from its own quarter-wave table.
// Each read is queued as a due pair of sums and compared with the done
// transfer. APB reads are checked against the tracked register values.
// ----------------------------------------------------------------------------

module spectrum_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          req_type,
    input  logic [1:0]          mode_index,
    input  logic [47:0]         event_time,
    input  logic [7:0]          bin_index,
    input  logic                done,
    input  logic signed [47:0]  real_sum,
    input  logic signed [47:0]  imag_sum,
    output int                  fail_count,
    output int                  outstanding,
    output int                  reads_checked
);

    localparam int LUT_BITS = 10;
    localparam int LUT_N    = 1 << LUT_BITS;
    localparam int LUT_Q    = LUT_N / 4;
    localparam int MODES    = 4;
    localparam int POINTS   = 256;

    typedef struct packed {
        logic signed [47:0] re;
        logic signed [47:0] im;
    } bin_sums_t;

    int        cos_lut [LUT_N];
    longint    cos_acc [MODES][POINTS];
    longint    sin_acc [MODES][POINTS];
    logic [31:0] step_reg;
    logic [8:0]  piu_reg;
    bin_sums_t   reads_due [$];

    initial
    begin
        fail_count    = 0;
        outstanding   = 0;
        reads_checked = 0;
    end

    // round(131071 * cos(pi/2 * j / LUT_Q)), Taylor series in Q62
    function automatic int quarter_wave(input int unsigned j);
        logic [127:0] prod;
        logic [63:0]  ang;
        logic [63:0]  ang_sq;
        logic [63:0]  trm;
        logic [63:0]  acc;
        logic [63:0]  scaled;
        if (j >= LUT_Q)
            return 0;
        ang    = (etsa_pkg::HALF_PI_Q62 >> (LUT_BITS - 2)) * 64'(j);
        prod   = {64'd0, ang} * {64'd0, ang};
        ang_sq = prod[125:62];
        trm    = etsa_pkg::ONE_Q62;
        acc    = etsa_pkg::ONE_Q62;
        for (int n = 1; n <= 13; n++)
        begin
            prod = {64'd0, trm} * {64'd0, ang_sq};
            trm  = prod[125:62] / 64'((2 * n - 1) * (2 * n));
            acc  = n[0] ? acc - trm : acc + trm;
        end
        scaled = (acc >> 20) * 64'd131071;
        return int'((scaled + (64'd1 << 41)) >> 42);
    endfunction

    initial
    begin
        for (int i = 0; i < LUT_N; i++)
        begin
            if (i <= LUT_Q)
                cos_lut[i] = quarter_wave(i);
            else if (i <= 2 * LUT_Q)
                cos_lut[i] = -quarter_wave(2 * LUT_Q - i);
            else if (i <= 3 * LUT_Q)
                cos_lut[i] = -quarter_wave(i - 2 * LUT_Q);
            else
                cos_lut[i] = quarter_wave(LUT_N - i);
        end
    end

    function automatic longint sat48(input longint r);
        longint hi;
        longint lo;
        hi = longint'(etsa_pkg::SUM_MAX);
        lo = longint'(etsa_pkg::SUM_MIN);
        if (r > hi)
            return hi;
        if (r < lo)
            return lo;
        return r;
    endfunction

    task automatic zero_sums();
        for (int m = 0; m < MODES; m++)
        begin
            for (int k = 0; k < POINTS; k++)
            begin
                cos_acc[m][k] = 0;
                sin_acc[m][k] = 0;
            end
        end
    endtask

    task automatic accumulate_event(input logic [1:0] mode, input logic [47:0] ticks);
        logic [63:0]        prod64;
        logic [31:0]        base;
        logic [31:0]        ph;
        logic [LUT_BITS-1:0] ci;
        logic [LUT_BITS-1:0] si;
        int                 npts;
        prod64 = {32'd0, ticks[31:0]} * {32'd0, step_reg};
        base   = prod64[31:0];
        npts   = (piu_reg > POINTS) ? POINTS : int'(piu_reg);
        for (int k = 0; k < npts; k++)
        begin
            ph = base * 32'(k + 1);
            ci = ph[31:32-LUT_BITS];
            si = ci - LUT_BITS'(LUT_Q);
            cos_acc[mode][k] = sat48(cos_acc[mode][k] + cos_lut[ci]);
            sin_acc[mode][k] = sat48(sin_acc[mode][k] + cos_lut[si]);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_sums_t   due;
        logic [31:0] reg_val;
        if (!rst_n)
        begin
            zero_sums();
            step_reg = '0;
            piu_reg  = etsa_pkg::PIU_RESET;
            reads_due.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                reg_val = (paddr[2] == etsa_pkg::REG_POINTS_IN_USE) ?
                          {23'd0, piu_reg} : step_reg;
                if (pwrite)
                begin
                    if (paddr[2] == etsa_pkg::REG_POINTS_IN_USE)
                        piu_reg = pwdata[8:0];
                    else
                        step_reg = pwdata;
                end
                else if (prdata !== reg_val)
                    report_mismatch($sformatf("register at 0x%0h reads 0x%0h, want 0x%0h",
                                              paddr, prdata, reg_val));
            end
            if (done)
            begin
                if (reads_due.size() == 0)
                    report_mismatch("read transfer with no read pending");
                else
                begin
                    due = reads_due.pop_front();
                    reads_checked++;
                    if (real_sum !== due.re)
                        report_mismatch($sformatf("real_sum %0d, want %0d",
                                                  real_sum, due.re));
                    if (imag_sum !== due.im)
                        report_mismatch($sformatf("imag_sum %0d, want %0d",
                                                  imag_sum, due.im));
                end
            end
            if (start && !busy)
            begin
                case (req_type)
                    etsa_pkg::REQ_ADD:
                        accumulate_event(mode_index, event_time);
                    etsa_pkg::REQ_READ:
                    begin
                        due.re = 48'(cos_acc[mode_index][bin_index]);
                        due.im = 48'(sin_acc[mode_index][bin_index]);
                        reads_due = {reads_due, due};
                    end
                    etsa_pkg::REQ_CLEAR:
                        zero_sums();
                    default: ;
                endcase
            end
        end
        outstanding = reads_due.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the event time spectrum accumulator
// Drives APB register setups and add, read, clear and unused requests, first
// a directed set, then random requests over several phase step and point
// count settings with varying start gaps. The checker predicts every read.
// ----------------------------------------------------------------------------

module tb;

    localparam int         QUIET_LIMIT  = 4000;
    localparam int         DRAIN_CYCLES = 300;
    localparam int         RANDOM_ITEMS = 1830;
    localparam int         PHASES       = 8;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic [1:0]         mode_index;
    logic [47:0]        event_time;
    logic [7:0]         bin_index;
    logic               done;
    logic signed [47:0] real_sum;
    logic signed [47:0] imag_sum;

    int fail_count;
    int outstanding;
    int reads_checked;
    int sender_idle;
    int quiet_cycles;
    int n_add;
    int n_read;
    int n_clear;
    int n_unused;
    int piu_now;

    event_time_spectrum_accumulator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .mode_index (mode_index),
        .event_time (event_time),
        .bin_index  (bin_index),
        .done       (done),
        .real_sum   (real_sum),
        .imag_sum   (imag_sum)
    );

    spectrum_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .mode_index    (mode_index),
        .event_time    (event_time),
        .bin_index     (bin_index),
        .done          (done),
        .real_sum      (real_sum),
        .imag_sum      (imag_sum),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .reads_checked (reads_checked)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable && pready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic wr, input logic sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] step, input logic [8:0] piu);
        apb_access(1'b1, etsa_pkg::REG_PHASE_STEP, step);
        apb_access(1'b1, etsa_pkg::REG_POINTS_IN_USE, {23'd0, piu});
        apb_access(1'b0, etsa_pkg::REG_PHASE_STEP, $urandom);
        apb_access(1'b0, etsa_pkg::REG_POINTS_IN_USE, $urandom);
        piu_now = (piu > 256) ? 256 : int'(piu);
    endtask

    task automatic submit(input logic [1:0] kind, input logic [1:0] mode,
                          input logic [47:0] ticks, input logic [7:0] bin);
        while ($urandom_range(99) < sender_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        req_type   <= kind;
        mode_index <= mode;
        event_time <= ticks;
        bin_index  <= bin;
        do
            @(posedge clk);
        while (busy);
        case (kind)
            etsa_pkg::REQ_ADD:   n_add++;
            etsa_pkg::REQ_READ:  n_read++;
            etsa_pkg::REQ_CLEAR: n_clear++;
            default:             n_unused++;
        endcase
    endtask

    // drop start, wait for every read to return, then let adds drain
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0 || busy);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_ticks();
        case ($urandom_range(4))
            0:       return 48'($urandom_range(1000));
            1:       return {16'hFFFF, 32'($urandom)};
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [7:0] rand_bin();
        if (piu_now > 0 && $urandom_range(9) < 7)
            return 8'($urandom_range(piu_now - 1));
        return 8'($urandom);
    endfunction

    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 46)
            submit(etsa_pkg::REQ_ADD, 2'($urandom), rand_ticks(), 8'($urandom));
        else if (pick < 92)
            submit(etsa_pkg::REQ_READ, 2'($urandom), rand_ticks(), rand_bin());
        else if (pick < 96)
            submit(etsa_pkg::REQ_CLEAR, 2'($urandom), rand_ticks(), 8'($urandom));
        else
            submit(REQ_UNUSED, 2'($urandom), rand_ticks(), 8'($urandom));
    endtask

    initial
    begin
        logic [31:0] step;
        logic [8:0]  piu;
        int          sent;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        req_type     = etsa_pkg::REQ_ADD;
        mode_index   = '0;
        event_time   = '0;
        bin_index    = '0;
        sender_idle  = 18;
        quiet_cycles = 0;
        n_add        = 0;
        n_read       = 0;
        n_clear      = 0;
        n_unused     = 0;
        piu_now      = 256;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, extremes of time, mode and bin, all request types
        submit(etsa_pkg::REQ_READ, 2'd0, '0, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd3, '1, 8'd255);
        submit(etsa_pkg::REQ_ADD, 2'd0, 48'd5, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd0, '0, 8'd255);
        settle();
        set_config(32'h9E37_79B9, 9'd256);
        submit(etsa_pkg::REQ_ADD, 2'd0, '0, '1);
        submit(etsa_pkg::REQ_ADD, 2'd3, '1, 8'd0);
        submit(etsa_pkg::REQ_ADD, 2'd1, 48'h8000_0000_0000, 8'd7);
        submit(etsa_pkg::REQ_ADD, 2'd2, 48'd1, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd0, '0, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd0, '1, 8'd255);
        submit(etsa_pkg::REQ_READ, 2'd3, '0, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd3, '0, 8'd255);
        submit(etsa_pkg::REQ_READ, 2'd1, '0, 8'd128);
        submit(etsa_pkg::REQ_READ, 2'd2, '0, 8'd1);
        submit(REQ_UNUSED, 2'd3, '1, '1);
        submit(etsa_pkg::REQ_READ, 2'd3, '0, 8'd255);
        submit(etsa_pkg::REQ_CLEAR, 2'd0, '0, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd3, '0, 8'd255);
        submit(etsa_pkg::REQ_READ, 2'd0, '0, 8'd0);
        submit(etsa_pkg::REQ_ADD, 2'd1, 48'h0000_FFFF_FFFF, 8'd0);
        submit(etsa_pkg::REQ_READ, 2'd1, '0, 8'd200);
        settle();

        sent = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin step = '1;            piu = 9'd256; end
                1:       begin step = 32'd1;         piu = 9'd1;   end
                2:       begin step = '0;            piu = 9'd0;   end
                3:       begin step = $urandom;      piu = 9'd300; end
                4:       begin step = 32'h8000_0000; piu = 9'd511; end
                5:       begin step = $urandom;      piu = 9'($urandom_range(2, 40)); end
                6:       begin step = $urandom;      piu = 9'($urandom_range(1, 256)); end
                default: begin step = $urandom;      piu = 9'($urandom_range(1, 16)); end
            endcase
            set_config(step, piu);
            while (sent < (ph + 1) * RANDOM_ITEMS / PHASES)
            begin
                sender_idle = (sent < RANDOM_ITEMS / 3) ? 18 :
                              (sent < 2 * RANDOM_ITEMS / 3) ? 75 : 0;
                random_request();
                sent = n_add + n_read + n_clear + n_unused - 21;
            end
            settle();
        end

        $display("covered %0d adds, %0d reads, %0d clears, %0d unused requests",
                 n_add, n_read, n_clear, n_unused);
        $display("%0d read transfers compared over %0d register settings",
                 reads_checked, PHASES + 1);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
